### sv/fsb_pkg.sv
// Shared types and constants for the flashlight mode and SOS blinker.
// No dependencies; every other file refers to it by scoped names.
package fsb_pkg;

   localparam int COUNT_BITS = 16;
   localparam int TICK_W     = 16;
   localparam int BLINK_W    = 4;
   localparam int UNIT_W     = 10;
   localparam int STEP_W     = 5;
   localparam int GAP_W      = UNIT_W + 3;
   // wide enough for a signed count difference and for 7 units
   localparam int CMP_W      = ((COUNT_BITS + 1) > GAP_W ? COUNT_BITS + 1 : GAP_W) + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_MASK_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOS_UNIT_TICKS  = 2'd1;

   localparam logic [BLINK_W-1:0] BLINK_MASK_BITS_RESET = 4'd4;
   localparam logic [UNIT_W-1:0]  SOS_UNIT_TICKS_RESET  = 10'd15;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;

   localparam logic [STEP_W-1:0] SOS_LAST_STEP = 5'd18;
   localparam logic [STEP_W-1:0] SOS_DASH_END0 = 5'd7;
   localparam logic [STEP_W-1:0] SOS_DASH_END1 = 5'd9;
   localparam logic [STEP_W-1:0] SOS_DASH_END2 = 5'd11;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_BLINK = 2'd2,
      MODE_SOS   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [BLINK_W-1:0] blink_mask_bits;
      logic [UNIT_W-1:0]  sos_unit_ticks;
   } cfg_type;

   typedef struct packed {
      logic              mode;
      logic [TICK_W-1:0] tick_count;
   } item_type;

   typedef struct packed {
      logic     lamp_on;
      mode_type light_mode;
   } result_type;

endpackage

### sv/fsb_if.sv
// Handshake channels of the blinker: request, response and register write.
// Depends on fsb_pkg for field widths.
interface fsb_req_if;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [fsb_pkg::TICK_W-1:0] tick_count;
   modport source (output valid, output mode, output tick_count, input ready);
   modport sink   (input valid, input mode, input tick_count, output ready);
endinterface

interface fsb_rsp_if;
   logic              valid;
   logic              ready;
   logic              lamp_on;
   logic [1:0]        light_mode;
   modport source (output valid, output lamp_on, output light_mode, input ready);
   modport sink   (input valid, input lamp_on, input light_mode, output ready);
endinterface

interface fsb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fsb_pkg::CSR_INDEX_W-1:0] index;
   logic [fsb_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/fsb_csr.sv
// Configuration registers: blink mask width and SOS time unit.
// Depends on fsb_pkg and fsb_csr_if.
module fsb_csr (
   input  logic              clock,
   input  logic              reset,
   fsb_csr_if.sink           csr_if,
   output fsb_pkg::cfg_type  cfg
);

   fsb_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            fsb_pkg::REG_BLINK_MASK_BITS:
               cfg_in.blink_mask_bits = csr_if.data[fsb_pkg::BLINK_W-1:0];
            fsb_pkg::REG_SOS_UNIT_TICKS:
               cfg_in.sos_unit_ticks = csr_if.data[fsb_pkg::UNIT_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_mask_bits <= fsb_pkg::BLINK_MASK_BITS_RESET;
         cfg_ff.sos_unit_ticks  <= fsb_pkg::SOS_UNIT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/fsb_lamp_state.sv
// Mode, lamp and SOS sequencer state with the per-item next-state logic.
// Depends on fsb_pkg.
module fsb_lamp_state (
   input  logic                clock,
   input  logic                reset,
   input  fsb_pkg::cfg_type    cfg,
   input  fsb_pkg::item_type   item,
   input  logic                advance,
   output fsb_pkg::result_type next_res
);

   fsb_pkg::mode_type                mode_ff, mode_in;
   logic                             lamp_ff, lamp_in;
   logic [fsb_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [fsb_pkg::COUNT_BITS-1:0]   due_ff, due_in;

   logic [fsb_pkg::COUNT_BITS-1:0]   cnt;
   logic [fsb_pkg::COUNT_BITS-1:0]   blink_mask;
   logic [fsb_pkg::GAP_W-1:0]        unit_x1, unit_x3, unit_x7, gap;
   logic [fsb_pkg::CMP_W-1:0]        diff, due_sum;
   logic                             late;

   assign cnt = fsb_pkg::COUNT_BITS'(item.tick_count);

   always_comb begin
      for (int i = 0; i < fsb_pkg::COUNT_BITS; i++) begin
         blink_mask[i] = (i < int'(cfg.blink_mask_bits));
      end
   end

   assign unit_x1 = fsb_pkg::GAP_W'(cfg.sos_unit_ticks);
   assign unit_x3 = (unit_x1 << 1) + unit_x1;
   assign unit_x7 = (unit_x1 << 3) - unit_x1;

   always_comb begin
      if (step_ff >= fsb_pkg::SOS_LAST_STEP) begin
         gap = unit_x7;
      end else begin
         case (step_ff) inside
            fsb_pkg::SOS_DASH_END0, fsb_pkg::SOS_DASH_END1,
            fsb_pkg::SOS_DASH_END2: gap = unit_x3;
            default:                gap = unit_x1;
         endcase
      end
   end

   // signed distance of the count past the due time
   assign diff    = fsb_pkg::CMP_W'(cnt) - fsb_pkg::CMP_W'(due_ff);
   assign late    = $signed(diff) > $signed(fsb_pkg::CMP_W'(unit_x7));
   assign due_sum = fsb_pkg::CMP_W'(cnt) + fsb_pkg::CMP_W'(gap);

   always_comb begin
      mode_in = mode_ff;
      lamp_in = lamp_ff;
      step_in = step_ff;
      due_in  = due_ff;
      if (item.mode == fsb_pkg::KIND_PRESS) begin
         if (mode_ff == fsb_pkg::MODE_OFF) lamp_in = 1'b1;
         else if (mode_ff == fsb_pkg::MODE_SOS) lamp_in = 1'b0;
         mode_in = fsb_pkg::mode_type'(mode_ff + 2'd1);
      end else if (mode_ff == fsb_pkg::MODE_BLINK) begin
         if ((cnt & blink_mask) == '0) lamp_in = ~lamp_ff;
      end else if (mode_ff == fsb_pkg::MODE_SOS) begin
         if (late) begin
            step_in = '0;
            due_in  = cnt + fsb_pkg::COUNT_BITS'(1);
         end else if (cnt == due_ff) begin
            lamp_in = (step_ff == '0) ? 1'b0 : ~lamp_ff;
            due_in  = due_sum[fsb_pkg::COUNT_BITS-1:0];
            // after the last step the sequence wraps to step 1
            step_in = (step_ff >= fsb_pkg::SOS_LAST_STEP) ? fsb_pkg::STEP_W'(1)
                                                          : step_ff + 1'b1;
         end
      end
   end

   assign next_res.lamp_on    = lamp_in;
   assign next_res.light_mode = mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fsb_pkg::MODE_OFF;
         lamp_ff <= 1'b0;
         step_ff <= '0;
         due_ff  <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         lamp_ff <= lamp_in;
         step_ff <= step_in;
         due_ff  <= due_in;
      end
   end

endmodule

### sv/flashlight_mode_and_sos_blinker.sv
// Top level of the flashlight mode and SOS blinker: input and result registers.
// Depends on fsb_pkg, fsb_if, fsb_csr and fsb_lamp_state.
//
//  channel | dir | handshake    | payload
//  req_if  | in  | valid/ready  | mode, tick_count
//  rsp_if  | out | valid/ready  | lamp_on, light_mode
//  csr_if  | in  | valid/ready  | index, data (always ready)
//
// One item per cycle sustained while the output is not stalled; a result shows on
// the output once its item has passed the input register, then one pass over the
// lamp state into the result register. Synchronous active-high reset clears both
// registers' valid flags and the lamp state. A stalled result holds while the input
// register still takes one more item.
module flashlight_mode_and_sos_blinker (
   input  logic      clock,
   input  logic      reset,
   fsb_req_if.sink   req_if,
   fsb_rsp_if.source rsp_if,
   fsb_csr_if.sink   csr_if
);

   fsb_pkg::cfg_type    cfg;
   fsb_pkg::item_type   item_ff;
   fsb_pkg::result_type res_ff, next_res;
   logic                in_valid_ff, in_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_if.valid && req_if.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   fsb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   fsb_lamp_state u_state (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .item     (item_ff),
      .advance  (advance),
      .next_res (next_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         item_ff.mode       <= req_if.mode;
         item_ff.tick_count <= req_if.tick_count;
      end
      if (advance) res_ff <= next_res;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.lamp_on    = res_ff.lamp_on;
   assign rsp_if.light_mode = res_ff.light_mode;

endmodule

### sv/fsb_checker.sv
// Port-level checks for the blinker, attached to the top level by bind.
// Depends on fsb_pkg.
module fsb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_lamp_on,
   input logic [1:0] rsp_light_mode
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire, rsp_fire;

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};

   always_ff @(posedge clock) begin
      if (reset) pending_ff <= '0;
      else       pending_ff <= pending_in;
   end

   // two registers deep: never more than two items in flight
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more items in flight than the pipeline holds");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result shown with no item outstanding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lamp_on)
                                   && $stable(rsp_light_mode))
      else $error("stalled result changed");

   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_light_mode == fsb_pkg::MODE_OFF |-> !rsp_lamp_on)
      else $error("lamp lit in off mode");

   a_on_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_light_mode == fsb_pkg::MODE_ON |-> rsp_lamp_on)
      else $error("lamp dark in on mode");

endmodule

bind flashlight_mode_and_sos_blinker fsb_checker u_fsb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_lamp_on    (rsp_if.lamp_on),
   .rsp_light_mode (rsp_if.light_mode)
);

### tb/flashlight_mode_and_sos_blinker_tb.sv
// Testbench for flashlight_mode_and_sos_blinker: self-checking, with random handshakes.
// Depends on fsb_pkg, the fsb_*_if interfaces and the blinker RTL.
`timescale 1ns / 100ps

module flashlight_mode_and_sos_blinker_tb;

   localparam int STUCK_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PRINT_LIMIT     = 100;

   // indexes past the register list, written to show they are ignored
   localparam logic [fsb_pkg::CSR_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [fsb_pkg::CSR_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

   typedef struct {
      fsb_pkg::mode_type              mode;
      logic                           lamp;
      logic [fsb_pkg::STEP_W-1:0]     step;
      logic [fsb_pkg::COUNT_BITS-1:0] due;
   } lamp_track_type;

   logic clock;
   logic reset;
   logic hold_off;

   fsb_req_if req_if();
   fsb_rsp_if rsp_if();
   fsb_csr_if csr_if();

   flashlight_mode_and_sos_blinker u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   fsb_pkg::cfg_type    cfg;
   lamp_track_type      queued_state;   // after every item queued so far
   lamp_track_type      taken_state;    // after every item the block has taken
   fsb_pkg::item_type   pending_items[$];
   fsb_pkg::item_type   offered_item;
   fsb_pkg::result_type expected_lamp[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int errors;
   int items_taken;
   int results_seen;
   int regs_written;
   int sos_ticks;
   int sos_rounds;
   int stuck_cycles;
   logic [fsb_pkg::STEP_W-1:0] prior_step;
   fsb_pkg::mode_type          prior_mode;

   always #2 clock = ~clock;

   // Lamp state after one press or tick.
   function automatic fsb_pkg::result_type lamp_next(inout lamp_track_type st,
                                                     input fsb_pkg::item_type it);
      logic [fsb_pkg::COUNT_BITS-1:0] cnt;
      logic [1:0]                     next_mode;
      int                             lateness;
      int                             unit;
      fsb_pkg::result_type            res;
      cnt  = it.tick_count[fsb_pkg::COUNT_BITS-1:0];
      unit = int'(cfg.sos_unit_ticks);
      if (it.mode == fsb_pkg::KIND_PRESS) begin
         if (st.mode == fsb_pkg::MODE_OFF)
            st.lamp = 1'b1;
         else if (st.mode == fsb_pkg::MODE_SOS)
            st.lamp = 1'b0;
         next_mode = st.mode + 2'd1;
         st.mode   = fsb_pkg::mode_type'(next_mode);
      end else if (st.mode == fsb_pkg::MODE_BLINK) begin
         if ((int'(cnt) & ((1 << cfg.blink_mask_bits) - 1)) == 0)
            st.lamp = ~st.lamp;
      end else if (st.mode == fsb_pkg::MODE_SOS) begin
         // plain signed difference, so a wrapped count never restarts
         lateness = int'(cnt) - int'(st.due);
         if (lateness > 7 * unit) begin
            st.step = '0;
            st.due  = cnt + 1'b1;
         end else if (cnt == st.due) begin
            st.lamp = (st.step == '0) ? 1'b0 : ~st.lamp;
            if (st.step >= fsb_pkg::SOS_LAST_STEP) begin
               st.due  = cnt + fsb_pkg::COUNT_BITS'(7 * unit);
               st.step = '0;
            end else if (st.step == fsb_pkg::SOS_DASH_END0 ||
                         st.step == fsb_pkg::SOS_DASH_END1 ||
                         st.step == fsb_pkg::SOS_DASH_END2) begin
               st.due = cnt + fsb_pkg::COUNT_BITS'(3 * unit);
            end else begin
               st.due = cnt + fsb_pkg::COUNT_BITS'(unit);
            end
            st.step = st.step + 1'b1;
         end
      end
      res.lamp_on    = st.lamp;
      res.light_mode = st.mode;
      return res;
   endfunction

   task automatic queue_item(input logic kind, input logic [fsb_pkg::TICK_W-1:0] cnt);
      fsb_pkg::item_type it;
      it.mode       = kind;
      it.tick_count = cnt;
      void'(lamp_next(queued_state, it));
      pending_items.push_back(it);
   endtask

   // Tick counts aimed at the lamp state the queue will have reached.
   function automatic logic [fsb_pkg::TICK_W-1:0] pick_tick_count();
      logic [fsb_pkg::COUNT_BITS-1:0] span;
      logic [fsb_pkg::TICK_W-1:0]     noise;
      int                             low_ones;
      noise    = fsb_pkg::TICK_W'($urandom);
      span     = fsb_pkg::COUNT_BITS'(7 * int'(cfg.sos_unit_ticks));
      low_ones = (1 << cfg.blink_mask_bits) - 1;
      if (queued_state.mode == fsb_pkg::MODE_BLINK)
         return $urandom_range(1) ? (noise & ~fsb_pkg::TICK_W'(low_ones)) : noise;
      if (queued_state.mode != fsb_pkg::MODE_SOS)
         return noise;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return queued_state.due;
         5: return queued_state.due + span;          // late by exactly the window
         6: return queued_state.due + span + 1'b1;   // one past the window
         7: return queued_state.due - fsb_pkg::TICK_W'($urandom_range(1, 3));
         8: return queued_state.due + fsb_pkg::TICK_W'($urandom_range(1, 1 + int'(span)));
         default: return noise;
      endcase
   endfunction

   task automatic queue_random(input int count);
      int press_pct;
      repeat (count) begin
         // stay in SOS long enough to run whole patterns
         press_pct = (queued_state.mode == fsb_pkg::MODE_SOS) ? 2 : 10;
         if ($urandom_range(99) < press_pct)
            queue_item(fsb_pkg::KIND_PRESS, fsb_pkg::TICK_W'($urandom));
         else
            queue_item(fsb_pkg::KIND_TICK, pick_tick_count());
      end
   endtask

   task automatic write_reg(input logic [fsb_pkg::CSR_INDEX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= fsb_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == fsb_pkg::REG_BLINK_MASK_BITS)
         cfg.blink_mask_bits = fsb_pkg::BLINK_W'(value);
      else if (idx == fsb_pkg::REG_SOS_UNIT_TICKS)
         cfg.sos_unit_ticks = fsb_pkg::UNIT_W'(value);
      regs_written++;
   endtask

   // sampled on the falling edge, once the rising-edge updates have settled
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_if.valid || expected_lamp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int blink, input int unit, input int idle_pct,
                            input int stall_pct, input int count, input bit pressure);
      wait_idle();
      write_reg(fsb_pkg::REG_BLINK_MASK_BITS, blink);
      write_reg(fsb_pkg::REG_SOS_UNIT_TICKS, unit);
      send_idle_pct <= idle_pct;
      rsp_stall_pct <= stall_pct;
      queue_random(count);
      if (pressure) begin
         // receiver holds off while the sender keeps offering
         fork
            begin
               hold_off <= 1'b1;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               hold_off <= 1'b0;
            end
         join_none
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < PRINT_LIMIT)
         $display("ERROR at result %0d: %s, got %0d, expected %0d",
                  results_seen, what, got, want);
      errors++;
   endtask

   // Driver: offers queued items, predicts each one as it is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            prior_step = taken_state.step;
            prior_mode = taken_state.mode;
            expected_lamp.push_back(lamp_next(taken_state, offered_item));
            items_taken++;
            if (prior_mode == fsb_pkg::MODE_SOS && offered_item.mode == fsb_pkg::KIND_TICK)
            begin
               sos_ticks++;
               if (prior_step == fsb_pkg::SOS_LAST_STEP && taken_state.step != prior_step)
                  sos_rounds++;
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_item       = pending_items.pop_front();
               req_if.valid      <= 1'b1;
               req_if.mode       <= offered_item.mode;
               req_if.tick_count <= offered_item.tick_count;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result against the oldest prediction.
   always @(posedge clock) begin
      fsb_pkg::result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_lamp.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_if.light_mode, -1);
            end else begin
               want = expected_lamp.pop_front();
               if (rsp_if.lamp_on !== want.lamp_on)
                  report_mismatch("lamp_on", rsp_if.lamp_on, want.lamp_on);
               if (rsp_if.light_mode !== want.light_mode)
                  report_mismatch("light_mode", rsp_if.light_mode, want.light_mode);
            end
         end
         rsp_if.ready <= !hold_off && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", stuck_cycles);
            $display("flashlight_mode_and_sos_blinker test failed");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      hold_off          = 1'b0;
      req_if.valid      = 1'b0;
      req_if.mode       = fsb_pkg::KIND_TICK;
      req_if.tick_count = '0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = fsb_pkg::REG_BLINK_MASK_BITS;
      csr_if.data       = '0;
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      errors            = 0;
      items_taken       = 0;
      results_seen      = 0;
      regs_written      = 0;
      sos_ticks         = 0;
      sos_rounds        = 0;
      stuck_cycles      = 0;
      cfg.blink_mask_bits = fsb_pkg::BLINK_MASK_BITS_RESET;
      cfg.sos_unit_ticks  = fsb_pkg::SOS_UNIT_TICKS_RESET;
      queued_state      = '{fsb_pkg::MODE_OFF, 1'b0, '0, '0};
      taken_state       = queued_state;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: every mode, blink edges, SOS hits, window edge, restarts, wrap
      queue_item(fsb_pkg::KIND_TICK, 16'h0000);
      queue_item(fsb_pkg::KIND_TICK, 16'hFFFF);
      queue_item(fsb_pkg::KIND_PRESS, 16'hA5A5);
      queue_item(fsb_pkg::KIND_TICK, 16'h0000);
      queue_item(fsb_pkg::KIND_PRESS, 16'h5A5A);
      queue_item(fsb_pkg::KIND_TICK, 16'h0010);
      queue_item(fsb_pkg::KIND_TICK, 16'h0011);
      queue_item(fsb_pkg::KIND_TICK, 16'hFFF0);
      queue_item(fsb_pkg::KIND_PRESS, 16'hFFFF);
      queue_item(fsb_pkg::KIND_TICK, queued_state.due);
      queue_item(fsb_pkg::KIND_TICK, queued_state.due);
      queue_item(fsb_pkg::KIND_TICK,
                 queued_state.due + fsb_pkg::TICK_W'(7 * int'(cfg.sos_unit_ticks)));
      queue_item(fsb_pkg::KIND_TICK,
                 queued_state.due + fsb_pkg::TICK_W'(7 * int'(cfg.sos_unit_ticks) + 1));
      queue_item(fsb_pkg::KIND_TICK, queued_state.due);
      queue_item(fsb_pkg::KIND_TICK, queued_state.due - 1'b1);
      queue_item(fsb_pkg::KIND_TICK, 16'hFFFF);   // restart, due wraps to zero
      queue_item(fsb_pkg::KIND_TICK, queued_state.due);
      queue_item(fsb_pkg::KIND_TICK, 16'hFFF0);
      queue_item(fsb_pkg::KIND_TICK, 16'h0003);   // count wrapped below due
      queue_item(fsb_pkg::KIND_TICK, queued_state.due);
      queue_item(fsb_pkg::KIND_PRESS, 16'h0000);
      queue_item(fsb_pkg::KIND_PRESS, 16'h0000);
      queue_item(fsb_pkg::KIND_PRESS, 16'h0000);

      wait_idle();
      write_reg(REG_SPARE_LO, 10'h3FF);
      write_reg(REG_SPARE_HI, 0);

      run_phase(1,  1,    0,  0,  250, 1'b0);
      run_phase(15, 1023, 73, 0,  200, 1'b0);
      run_phase(0,  0,    0,  73, 200, 1'b0);
      run_phase(3,  2,    30, 30, 250, 1'b0);
      run_phase(2,  5,    0,  0,  150, 1'b1);
      run_phase(7,  1000, 30, 30, 150, 1'b0);
      run_phase(1,  4,    0,  0,  150, 1'b0);
      wait_idle();

      if (expected_lamp.size() != 0)
         report_mismatch("results never delivered", 0, expected_lamp.size());
      $display("covered %0d items and %0d results over %0d register writes",
               items_taken, results_seen, regs_written);
      $display("SOS: %0d ticks, %0d full patterns; %0d mismatches",
               sos_ticks, sos_rounds, errors);
      if (errors == 0)
         $display("flashlight_mode_and_sos_blinker test passed");
      else
         $display("flashlight_mode_and_sos_blinker test failed");
      $finish;
   end

endmodule

### flashlight_mode_and_sos_blinker.f
sv/fsb_pkg.sv
sv/fsb_if.sv
sv/fsb_csr.sv
sv/fsb_lamp_state.sv
sv/flashlight_mode_and_sos_blinker.sv
sv/fsb_checker.sv
tb/flashlight_mode_and_sos_blinker_tb.sv
